// ----- hdl/bpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants, types and the binomial coefficient table for the
// Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

	localparam int MAX_POINTS = 10;
	localparam int STEPS      = 1024;

	localparam int COORD_W = 12;
	localparam int STEP_W  = 10;
	localparam int DEG_W   = 4;
	localparam int PIDX_W  = 4;
	localparam int IDX_W   = $clog2(MAX_POINTS);

	// unsigned Q1.20
	localparam int FRAC_W = 20;
	localparam int Q_W    = FRAC_W + 1;
	localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;
	localparam logic [Q_W-1:0] HALF_Q = Q_W'(1) << (FRAC_W - 1);

	// u = step / DEN, done as a reciprocal multiply plus one correction
	localparam int DEN   = STEPS - 1;
	localparam int DEN_W = $clog2(STEPS);
	localparam int X_W   = STEP_W + FRAC_W;
	localparam longint unsigned RECIP_L = (longint'(1) << X_W) / longint'(DEN);
	localparam logic [X_W:0] RECIP = (X_W + 1)'(RECIP_L);

	// C(n,k) < 2^n for n >= 1
	localparam int BINOM_W = MAX_POINTS - 1;
	localparam int W_W     = Q_W + BINOM_W;
	localparam int PROD_W  = COORD_W + W_W + 1;
	localparam int ACC_W   = PROD_W + IDX_W;
	localparam int R_W     = ACC_W - FRAC_W;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_W-1:0] binom_tab_t;

	typedef struct packed {
		logic                      valid;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} ld_req_t;

	typedef struct packed {
		logic           valid;
		logic [Q_W-1:0] uq;
	} ustep_t;

	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} res_t;

	// Pascal's triangle, built at elaboration
	function automatic binom_tab_t build_binom();
		binom_tab_t t;
		t = '0;
		t[0][0] = BINOM_W'(1);
		for (int r = 1; r < MAX_POINTS; r++) begin
			for (int c = 0; c <= r; c++) begin
				t[r][c] = ((c > 0) ? t[r-1][c-1] : BINOM_W'(0)) +
					((c < r) ? t[r-1][c] : BINOM_W'(0));
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM = build_binom();

endpackage

// ----- hdl/bezier_point_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// Bezier curve point evaluation in Bernstein form, Q1.20 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_data): writes the curve degree;
//   always ready. Write it only while no evaluate request is in flight.
//   Input channel (in_valid/in_stall): kind 0 loads control point
//   point_index with coord_x/coord_y and returns nothing; kind 1 evaluates
//   the curve at step and returns one curve_x/curve_y result.
//   Output channel (out_valid/out_stall): result register; a stalled result
//   holds until taken.
// Sequencing:
//   A load writes the control point store directly. An evaluate request
//   reaches the output register in steps, n the effective degree: u from
//   step, the powers of (1-u) up to n, the multiply-accumulate sequencer
//   for each control point, round and clamp. in_stall is high until the
//   result leaves the core; one request is worked on at a time. A new
//   request is taken while a finished result still waits on out_stall.
// Reset: degree returns to 1, the pipeline empties. Control points are not
//   cleared; evaluate only after loading points 0..n.
// ----------------------------------------------------------------------------
module bezier_point_evaluator
	import bpe_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [DEG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [PIDX_W-1:0]         point_index,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic [STEP_W-1:0]         step,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] curve_x,
	output logic signed [COORD_W-1:0] curve_y
);

	logic [DEG_W-1:0]          degree_q;
	logic                      busy_q;
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;

	logic             in_acc;
	logic             eval_start;
	logic             res_take;
	logic [IDX_W-1:0] n_eff;
	ld_req_t          ld;
	ustep_t           ustep;
	res_t             res;

	assign cfg_ready  = 1'b1;
	assign in_stall   = busy_q;
	assign in_acc     = in_valid && !busy_q;
	assign eval_start = in_acc && (kind == KIND_EVAL);

	assign ld.valid = in_acc && (kind == KIND_LOAD) && (32'(point_index) < MAX_POINTS);
	assign ld.idx   = IDX_W'(point_index);
	assign ld.x     = coord_x;
	assign ld.y     = coord_y;

	always_comb begin
		if (degree_q == '0) begin
			n_eff = IDX_W'(1);
		end else if (32'(degree_q) > MAX_POINTS - 1) begin
			n_eff = IDX_W'(MAX_POINTS - 1);
		end else begin
			n_eff = IDX_W'(degree_q);
		end
	end

	assign res_take = res.valid && (!out_valid_q || !out_stall);

	bpe_ustep u_ustep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eval_start),
		.step   (step),
		.res    (ustep)
	);

	bpe_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.ustep    (ustep),
		.n        (n_eff),
		.res_take (res_take),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q    <= DEG_W'(1);
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				degree_q <= cfg_data;
			end
			if (eval_start) begin
				busy_q <= 1'b1;
			end else if (res_take) begin
				busy_q <= 1'b0;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_x_q <= res.x;
			out_y_q <= res.y;
		end
	end

	assign out_valid = out_valid_q;
	assign curve_x   = out_x_q;
	assign curve_y   = out_y_q;

endmodule

// ----- hdl/bpe_ustep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_ustep
// Converts a step index into u = step / (STEPS-1) in Q1.20, rounded to
// nearest. Four pipeline stages: operand, reciprocal product, quotient
// estimate, correction.
// ----------------------------------------------------------------------------
module bpe_ustep
	import bpe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STEP_W-1:0] step,
	output ustep_t            res
);

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic [X_W-1:0]       x_s1, x_s2, x_s3;
	logic [2*X_W:0]       prod_s2;
	logic [Q_W-1:0]       q0_s3;
	logic [Q_W+DEN_W-1:0] qd_s3;
	logic [Q_W-1:0]       uq_s4;
	logic [STEP_W-1:0]    step_c;
	logic [X_W:0]         rem;
	logic [Q_W-1:0]       q0;

	always_comb begin
		if (32'(step) > 32'(DEN)) begin
			step_c = STEP_W'(DEN);
		end else begin
			step_c = step;
		end
	end

	assign q0  = prod_s2[X_W +: Q_W];
	assign rem = (X_W + 1)'(x_s3) - (X_W + 1)'(qd_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= {step_c, FRAC_W'(0)} + X_W'(DEN / 2);
		prod_s2 <= (2 * X_W + 1)'(x_s1) * (2 * X_W + 1)'(RECIP);
		x_s2    <= x_s1;
		q0_s3   <= q0;
		qd_s3   <= (Q_W + DEN_W)'(q0) * (Q_W + DEN_W)'(DEN);
		x_s3    <= x_s2;
		// estimate is exact or one short
		if (rem >= (X_W + 1)'(DEN)) begin
			uq_s4 <= q0_s3 + Q_W'(1);
		end else begin
			uq_s4 <= q0_s3;
		end
	end

	assign res.valid = valid_s4;
	assign res.uq    = uq_s4;

endmodule

// ----- hdl/bpe_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_core
// Control point store and Bernstein sum sequencer. Powers of (1-u) are
// built into a small memory first; the sum then walks k = 0..n, reading the
// control point at k and (1-u)^(n-k) while carrying u^k in a register.
// ----------------------------------------------------------------------------
module bpe_core
	import bpe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ld_req_t          ld,
	input  ustep_t           ustep,
	input  logic [IDX_W-1:0] n,
	input  logic             res_take,
	output res_t             res
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PVMUL = 4'd1;
	localparam logic [3:0] ST_PVRND = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_M1    = 4'd4;
	localparam logic [3:0] ST_M2    = 4'd5;
	localparam logic [3:0] ST_M3    = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_RND   = 4'd8;
	localparam logic [3:0] ST_CLP   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
	logic [Q_W-1:0]       pv_mem [MAX_POINTS];
	logic [2*COORD_W-1:0] pt_rd_q;
	logic [Q_W-1:0]       pv_rd_q;

	logic [3:0]       state_q;
	logic [IDX_W-1:0] k_q, n_q;

	logic [Q_W-1:0]             uq_q, vq_q, pv_run_q, pu_run_q;
	logic [2*Q_W-1:0]           vprod_q, tprod_q, uprod_q;
	logic [W_W-1:0]             w_q;
	logic signed [COORD_W-1:0]  px_q, py_q, lox_q, hix_q, loy_q, hiy_q;
	logic signed [PROD_W-1:0]   prodx_q, prody_q;
	logic signed [ACC_W-1:0]    sx_q, sy_q;
	logic signed [R_W-1:0]      rx_q, ry_q;
	logic signed [COORD_W-1:0]  resx_q, resy_q;

	logic                      pv_we;
	logic [IDX_W-1:0]          pv_waddr;
	logic [Q_W-1:0]            pv_wdata;
	logic [2*Q_W-1:0]          vsum, tsum, usum;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic signed [ACC_W-1:0]   bias_x, bias_y, rsx, rsy;

	assign vsum = vprod_q + (2 * Q_W)'(HALF_Q);
	assign tsum = tprod_q + (2 * Q_W)'(HALF_Q);
	assign usum = uprod_q + (2 * Q_W)'(HALF_Q);
	assign rd_x = pt_rd_q[2*COORD_W-1:COORD_W];
	assign rd_y = pt_rd_q[COORD_W-1:0];

	// half away from zero: negative sums take one less before the floor shift
	assign bias_x = sx_q[ACC_W-1] ? ACC_W'(HALF_Q) - ACC_W'(1) : ACC_W'(HALF_Q);
	assign bias_y = sy_q[ACC_W-1] ? ACC_W'(HALF_Q) - ACC_W'(1) : ACC_W'(HALF_Q);
	assign rsx    = sx_q + bias_x;
	assign rsy    = sy_q + bias_y;

	always_comb begin
		pv_we    = 1'b0;
		pv_waddr = k_q;
		pv_wdata = vsum[FRAC_W +: Q_W];
		if (state_q == ST_IDLE && ustep.valid) begin
			pv_we    = 1'b1;
			pv_waddr = '0;
			pv_wdata = ONE_Q;
		end else if (state_q == ST_PVRND) begin
			pv_we = 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (ld.valid) begin
			pt_mem[ld.idx] <= {ld.x, ld.y};
		end
		if (pv_we) begin
			pv_mem[pv_waddr] <= pv_wdata;
		end
		pt_rd_q <= pt_mem[k_q];
		pv_rd_q <= pv_mem[n_q - k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			n_q     <= IDX_W'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ustep.valid) begin
						n_q     <= n;
						k_q     <= IDX_W'(1);
						state_q <= ST_PVMUL;
					end
				end
				ST_PVMUL: begin
					state_q <= ST_PVRND;
				end
				ST_PVRND: begin
					if (k_q == n_q) begin
						k_q     <= '0;
						state_q <= ST_RD;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= ST_PVMUL;
					end
				end
				ST_RD: begin
					state_q <= ST_M1;
				end
				ST_M1: begin
					state_q <= ST_M2;
				end
				ST_M2: begin
					state_q <= ST_M3;
				end
				ST_M3: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (k_q == n_q) begin
						state_q <= ST_RND;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_RND: begin
					state_q <= ST_CLP;
				end
				ST_CLP: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				uq_q     <= ustep.uq;
				vq_q     <= ONE_Q - ustep.uq;
				pv_run_q <= ONE_Q;
				pu_run_q <= ONE_Q;
				sx_q     <= '0;
				sy_q     <= '0;
			end
			ST_PVMUL: begin
				vprod_q <= (2 * Q_W)'(pv_run_q) * (2 * Q_W)'(vq_q);
			end
			ST_PVRND: begin
				pv_run_q <= vsum[FRAC_W +: Q_W];
			end
			ST_M1: begin
				tprod_q <= (2 * Q_W)'(pu_run_q) * (2 * Q_W)'(pv_rd_q);
				uprod_q <= (2 * Q_W)'(pu_run_q) * (2 * Q_W)'(uq_q);
				px_q    <= rd_x;
				py_q    <= rd_y;
				// running range of the control points used
				if (k_q == '0) begin
					lox_q <= rd_x;
					hix_q <= rd_x;
					loy_q <= rd_y;
					hiy_q <= rd_y;
				end else begin
					if (rd_x < lox_q) lox_q <= rd_x;
					if (rd_x > hix_q) hix_q <= rd_x;
					if (rd_y < loy_q) loy_q <= rd_y;
					if (rd_y > hiy_q) hiy_q <= rd_y;
				end
			end
			ST_M2: begin
				w_q      <= W_W'(BINOM[n_q][k_q]) * W_W'(tsum[FRAC_W +: Q_W]);
				pu_run_q <= usum[FRAC_W +: Q_W];
			end
			ST_M3: begin
				prodx_q <= px_q * $signed({1'b0, w_q});
				prody_q <= py_q * $signed({1'b0, w_q});
			end
			ST_ACC: begin
				sx_q <= sx_q + ACC_W'(prodx_q);
				sy_q <= sy_q + ACC_W'(prody_q);
			end
			ST_RND: begin
				rx_q <= rsx[ACC_W-1:FRAC_W];
				ry_q <= rsy[ACC_W-1:FRAC_W];
			end
			ST_CLP: begin
				if (rx_q < R_W'(lox_q)) begin
					resx_q <= lox_q;
				end else if (rx_q > R_W'(hix_q)) begin
					resx_q <= hix_q;
				end else begin
					resx_q <= rx_q[COORD_W-1:0];
				end
				if (ry_q < R_W'(loy_q)) begin
					resy_q <= loy_q;
				end else if (ry_q > R_W'(hiy_q)) begin
					resy_q <= hiy_q;
				end else begin
					resy_q <= ry_q[COORD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid = (state_q == ST_OUT);
	assign res.x     = resx_q;
	assign res.y     = resy_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bezier_point_evaluator. A short directed table hits
// the coordinate and step extremes, out-of-range degree and load index, and
// the control point clamp. Random phases then reload the control points and
// evaluate at random steps across several degrees. Both handshakes idle at
// random. Every result is compared against a Q1.20 Bernstein predictor kept
// inside the bench, or against the expected value of a typed directed row.
// ----------------------------------------------------------------------------
module testbench;
	import bpe_pkg::*;

	localparam int CLK_HALF_NS   = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 100;	// outlasts the slowest evaluate, at degree 9
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 400;
	localparam int PHASE_ITEMS   = 40;
	localparam int RUN_LIMIT_NS  = 6_000_000;

	localparam int              EVAL_FRAC   = 20;
	localparam longint unsigned Q_UNIT      = 64'd1 << EVAL_FRAC;
	localparam longint unsigned Q_HALF_UNIT = 64'd1 << (EVAL_FRAC - 1);
	localparam longint unsigned STEP_DEN    = STEPS - 1;
	localparam int              MAX_DEG     = MAX_POINTS - 1;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_op_e;

	typedef struct packed {
		logic                      kind;
		logic [PIDX_W-1:0]         idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [STEP_W-1:0]         step;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} curve_pt_t;

	typedef struct {
		row_op_e op;
		int      a;
		int      x;
		int      y;
		int      s;
		bit      typed;
		int      ex;
		int      ey;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [DEG_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      kind;
	logic [PIDX_W-1:0]         point_index;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic [STEP_W-1:0]         step;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [COORD_W-1:0] curve_x;
	logic signed [COORD_W-1:0] curve_y;

	// bench copy of the block state
	logic [DEG_W-1:0] degree_cfg;
	int               ctrl_x[MAX_POINTS];
	int               ctrl_y[MAX_POINTS];
	curve_pt_t        curve_q[$];
	row_t             dir_rows[$];
	int               err_count;
	bit               tx_calm;
	bit               rx_calm;
	bit               hold_ask;

	bezier_point_evaluator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.point_index(point_index),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.step       (step),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.curve_x    (curve_x),
		.curve_y    (curve_y)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF_NS;
		clk = 1'b1;
		#CLK_HALF_NS;
	end

	function automatic int eff_degree();
		int n;
		n = degree_cfg;
		if (n < 1) n = 1;
		if (n > MAX_DEG) n = MAX_DEG;
		return n;
	endfunction

	// round half away from zero out of Q.20, then clamp to the point range
	function automatic int round_clamp(input longint s, input int lo, input int hi);
		longint unsigned mag;
		longint          r;
		if (s >= 0) begin
			mag = s;
			r = longint'((mag + Q_HALF_UNIT) >> EVAL_FRAC);
		end else begin
			mag = -s;
			r = -longint'((mag + Q_HALF_UNIT) >> EVAL_FRAC);
		end
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return int'(r);
	endfunction

	function automatic curve_pt_t bernstein_point(input logic [STEP_W-1:0] s);
		longint unsigned pu[MAX_POINTS];
		longint unsigned pv[MAX_POINTS];
		longint unsigned uq, vq, binom, w, st;
		longint          sx, sy;
		int              lo_x, hi_x, lo_y, hi_y, n;
		curve_pt_t       pt;
		n = eff_degree();
		st = s;
		if (st > STEP_DEN) st = STEP_DEN;
		uq = (st * Q_UNIT + STEP_DEN / 2) / STEP_DEN;
		vq = Q_UNIT - uq;
		pu[0] = Q_UNIT;
		pv[0] = Q_UNIT;
		for (int k = 1; k <= n; k++) begin
			pu[k] = (pu[k-1] * uq + Q_HALF_UNIT) >> EVAL_FRAC;
			pv[k] = (pv[k-1] * vq + Q_HALF_UNIT) >> EVAL_FRAC;
		end
		binom = 1;
		sx = 0;
		sy = 0;
		lo_x = ctrl_x[0];
		hi_x = ctrl_x[0];
		lo_y = ctrl_y[0];
		hi_y = ctrl_y[0];
		for (int k = 0; k <= n; k++) begin
			w = binom * ((pu[k] * pv[n-k] + Q_HALF_UNIT) >> EVAL_FRAC);
			sx += longint'(ctrl_x[k]) * longint'(w);
			sy += longint'(ctrl_y[k]) * longint'(w);
			if (ctrl_x[k] < lo_x) lo_x = ctrl_x[k];
			if (ctrl_x[k] > hi_x) hi_x = ctrl_x[k];
			if (ctrl_y[k] < lo_y) lo_y = ctrl_y[k];
			if (ctrl_y[k] > hi_y) hi_y = ctrl_y[k];
			binom = binom * (n - k) / (k + 1);
		end
		pt.x = COORD_W'(round_clamp(sx, lo_x, hi_x));
		pt.y = COORD_W'(round_clamp(sy, lo_y, hi_y));
		return pt;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(7))
			0: return {1'b1, {(COORD_W-1){1'b0}}};
			1: return {1'b0, {(COORD_W-1){1'b1}}};
			2: return '0;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic req_t load_req(input int idx);
		req_t r;
		r.kind = KIND_LOAD;
		r.idx  = PIDX_W'(idx);
		r.x    = rand_coord();
		r.y    = rand_coord();
		r.step = STEP_W'($urandom);
		return r;
	endfunction

	function automatic req_t eval_req();
		req_t r;
		int   pick;
		pick = $urandom_range(9);
		r.kind = KIND_EVAL;
		r.idx  = PIDX_W'($urandom);
		r.x    = COORD_W'($urandom);
		r.y    = COORD_W'($urandom);
		if (pick == 0) r.step = '0;
		else if (pick == 1) r.step = '1;
		else r.step = STEP_W'($urandom);
		return r;
	endfunction

	function automatic void add_row(input row_op_e op, input int a, input int x, input int y,
		input int s, input bit typed = 1'b0, input int ex = 0, input int ey = 0);
		row_t row;
		row.op = op;
		row.a = a;
		row.x = x;
		row.y = y;
		row.s = s;
		row.typed = typed;
		row.ex = ex;
		row.ey = ey;
		dir_rows.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input logic signed [COORD_W-1:0] want,
		input logic signed [COORD_W-1:0] got);
		$display("%0t: mismatch %s: expected %0d, got %0d", $time, what, want, got);
		err_count++;
	endtask

	// present one request and hold it until taken; the bench state follows
	task automatic offer(input req_t r, input bit typed = 1'b0, input curve_pt_t known = '0);
		int gap;
		in_valid <= 1'b1;
		kind <= r.kind;
		point_index <= r.idx;
		coord_x <= r.x;
		coord_y <= r.y;
		step <= r.step;
		do @(posedge clk); while (in_stall);
		if (r.kind == KIND_LOAD) begin
			if (r.idx < MAX_POINTS) begin
				ctrl_x[r.idx] = r.x;
				ctrl_y[r.idx] = r.y;
			end
		end else begin
			curve_q.push_back(typed ? known : bernstein_point(r.step));
		end
		gap = tx_calm ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// loads give no result, so wait out a full evaluate after the queue drains
	task automatic settle();
		in_valid <= 1'b0;
		while (curve_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_degree(input logic [DEG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		degree_cfg = d;
	endtask

	initial begin
		req_t      rq;
		curve_pt_t kn;
		int        n, made, phase, r;
		logic [DEG_W-1:0] d;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_LOAD;
		point_index = '0;
		coord_x = '0;
		coord_y = '0;
		step = '0;
		err_count = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_ask = 1'b0;
		degree_cfg = 1;
		foreach (ctrl_x[i]) begin
			ctrl_x[i] = 0;
			ctrl_y[i] = 0;
		end

		// degree 1 after reset: endpoints come back exactly
		add_row(ROW_LOAD, 0, -2048, 2047, 0);
		add_row(ROW_LOAD, 1, 2047, -2048, 0);
		add_row(ROW_EVAL, 0, 0, 0, 0, 1'b1, -2048, 2047);
		add_row(ROW_EVAL, 0, 0, 0, 1023, 1'b1, 2047, -2048);
		// index past the store is dropped
		add_row(ROW_LOAD, 15, 1, 1, 0);
		add_row(ROW_CFG, 9, 0, 0, 0);
		add_row(ROW_LOAD, 2, 0, 0, 0);
		add_row(ROW_LOAD, 3, -1, 1, 0);
		add_row(ROW_LOAD, 4, 1000, -1000, 0);
		add_row(ROW_LOAD, 5, -2048, -2048, 0);
		add_row(ROW_LOAD, 6, 2047, 2047, 0);
		add_row(ROW_LOAD, 7, -5, 300, 0);
		add_row(ROW_LOAD, 8, 123, -456, 0);
		add_row(ROW_LOAD, 9, -700, 2000, 0);
		add_row(ROW_EVAL, 0, 0, 0, 0, 1'b1, -2048, 2047);
		add_row(ROW_EVAL, 0, 0, 0, 1023, 1'b1, -700, 2000);
		add_row(ROW_EVAL, 0, 0, 0, 300);
		// degree above the top acts as the top, zero acts as one
		add_row(ROW_CFG, 15, 0, 0, 0);
		add_row(ROW_EVAL, 0, 0, 0, 700);
		add_row(ROW_CFG, 0, 0, 0, 0);
		add_row(ROW_EVAL, 0, 0, 0, 512);
		// equal points: weight drift must be clamped away
		add_row(ROW_CFG, 2, 0, 0, 0);
		add_row(ROW_LOAD, 0, 2047, -2048, 0);
		add_row(ROW_LOAD, 1, 2047, -2048, 0);
		add_row(ROW_LOAD, 2, 2047, -2048, 0);
		add_row(ROW_EVAL, 0, 0, 0, 341, 1'b1, 2047, -2048);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].op)
				ROW_CFG: begin
					settle();
					write_degree(DEG_W'(dir_rows[i].a));
				end
				ROW_LOAD: begin
					rq = load_req(dir_rows[i].a);
					rq.x = COORD_W'(dir_rows[i].x);
					rq.y = COORD_W'(dir_rows[i].y);
					offer(rq);
				end
				default: begin
					rq = eval_req();
					rq.step = STEP_W'(dir_rows[i].s);
					kn.x = COORD_W'(dir_rows[i].ex);
					kn.y = COORD_W'(dir_rows[i].ey);
					offer(rq, dir_rows[i].typed, kn);
				end
			endcase
		end

		made = 0;
		phase = 0;
		while (made < RANDOM_ITEMS) begin
			case (phase)
				0: d = 9;
				1: d = 1;
				2: d = 0;
				3: d = 15;
				4: d = 9;
				default: d = DEG_W'($urandom);
			endcase
			settle();
			write_degree(d);
			tx_calm = (phase % 4 == 1) || (phase == 3);
			rx_calm = (phase % 4 == 1);
			// receiver holds off while the sender keeps pushing evaluates
			if (phase == 3) hold_ask = 1'b1;
			n = eff_degree();
			for (int k = 0; k <= n; k++) begin
				offer(load_req(k));
				made++;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 6 && i == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (curve_q.size() != 0) @(posedge clk);
				end
				r = $urandom_range(99);
				if (r < 65) rq = eval_req();
				else if (r < 82) rq = load_req($urandom_range(n));
				else rq = load_req($urandom_range(15));
				offer(rq);
				if (rq.kind == KIND_EVAL || rq.idx < MAX_POINTS) made++;
			end
			phase++;
		end

		settle();
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// output stall: random runs, a quiet mode, and one long hold on request
	initial begin
		int run;
		int len;
		bit held;
		run = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !held) begin
				held = 1'b1;
				run = HOLD_CYCLES;
			end
			if (run > 0) begin
				out_stall <= 1'b1;
				run--;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
			end else begin
				len = idle_len();
				out_stall <= (len > 0);
				if (len > 0) run = len - 1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		curve_pt_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (curve_q.size() == 0) begin
				report_mismatch("result with nothing pending, curve_x", '0, curve_x);
			end else begin
				want = curve_q.pop_front();
				if (curve_x !== want.x) report_mismatch("curve_x", want.x, curve_x);
				if (curve_y !== want.y) report_mismatch("curve_y", want.y, curve_y);
			end
		end
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bpe_pkg.sv
hdl/bpe_ustep.sv
hdl/bpe_core.sv
hdl/bezier_point_evaluator.sv
tb/testbench.sv
